[rtl/mfa_pkg.sv]
// Package for the network inference block: load codes, register indexes,
// controller states, the command bundle and the activation functions.
// No dependencies.
package mfa_pkg;

  // Input item modes.
  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Layer select code for the output layer.
  localparam logic [2:0] LSEL_OUTPUT = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INPUT_COUNT  = 3'd0;
  localparam logic [2:0] CFG_OUTPUT_COUNT = 3'd1;
  localparam logic [2:0] CFG_LAYER_COUNT  = 3'd2;
  localparam logic [2:0] CFG_HIDDEN1      = 3'd3;
  localparam logic [2:0] CFG_HIDDEN2      = 3'd4;
  localparam logic [2:0] CFG_HIDDEN3      = 3'd5;
  localparam logic [2:0] CFG_HIDDEN4      = 3'd6;
  localparam logic [2:0] CFG_ACT_MODE     = 3'd7;

  typedef enum logic [1:0] {
    ACT_LEAKY,
    ACT_TANH,
    ACT_SIGMOID,
    ACT_IDENTITY
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_SAT,
    ST_ACT,
    ST_ORD,
    ST_LOAD,
    ST_OUT
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic bias_rd;
    logic mac_rd;
    logic src_act;
    logic acc_load;
    logic sat_en;
    logic act_wr;
    logic out_layer;
    logic arg_first;
    logic out_rd;
    logic out_load;
    logic res_last;
  } dp_cmd_t;

  function automatic int clamp_int(int v, int lo, int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Tanh sample points at steps of 0.5 in Q4.12.
  function automatic logic [12:0] tanh_point(logic [3:0] i);
    logic [12:0] r;
    case (i)
      4'd0:    r = 13'd0;
      4'd1:    r = 13'd1893;
      4'd2:    r = 13'd3119;
      4'd3:    r = 13'd3707;
      4'd4:    r = 13'd3949;
      4'd5:    r = 13'd4041;
      4'd6:    r = 13'd4076;
      4'd7:    r = 13'd4089;
      4'd8:    r = 13'd4093;
      4'd9:    r = 13'd4095;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

  // Linear interpolation of tanh on a magnitude.
  function automatic logic [12:0] tanh_mag(logic [16:0] m);
    logic [5:0]  i;
    logic [10:0] f;
    logic [12:0] lo;
    logic [12:0] hi;
    logic [10:0] diff;
    logic [21:0] prod;
    logic [12:0] r;
    i    = m[16:11];
    f    = m[10:0];
    lo   = tanh_point(i[3:0]);
    hi   = tanh_point(i[3:0] + 4'd1);
    diff = 11'(hi - lo);
    prod = 22'(diff * f);
    r    = lo + 13'(prod[21:11]);
    if (i >= 6'd10) r = 13'd4096;
    return r;
  endfunction

  function automatic logic signed [15:0] mfa_activate(logic signed [15:0] x, act_e kind);
    logic signed [16:0] xs;
    logic [16:0]        m;
    logic [12:0]        t;
    logic [12:0]        th;
    logic signed [15:0] r;
    xs = {x[15], x};
    m  = x[15] ? 17'(-xs) : 17'(xs);
    case (kind)
      ACT_LEAKY: begin
        r = (x > 16'sd0) ? x : (x >>> 10);
      end
      ACT_TANH: begin
        t = tanh_mag(m);
        r = x[15] ? -$signed({3'b000, t}) : $signed({3'b000, t});
      end
      ACT_SIGMOID: begin
        t  = tanh_mag(m >> 1);
        th = t >> 1;
        r  = x[15] ? $signed(16'(13'd2048 - th)) : $signed(16'({1'b0, th} + 14'd2048));
      end
      default: begin
        r = x;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/mlp_forward_argmax_top.sv]
// Top level of the network inference block: joins the controller and the
// datapath and holds the port assertions. Depends on mfa_pkg, mfa_ctrl, mfa_dpath.

// Weight, bias and sample load items each take one transfer. The element
// flagged last starts a pass over all layers through one shared multiplier:
// each neuron reads its bias, then one weight per input of its layer, via
// the one weight memory read port and the three-stage read, multiply and
// accumulate chain. Each output layer result is then held in the output
// register until taken. No input item is taken while a pass or result pends.
module mlp_forward_argmax_top #(
  parameter int MAX_INPUTS = 32,
  parameter int MAX_WIDTH = 32,
  parameter int MAX_OUTPUTS = 16,
  parameter int MAX_HIDDEN_LAYERS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         layer_select_i,
  input  logic [4:0]         row_i,
  input  logic [4:0]         column_i,
  input  logic signed [15:0] value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         output_index_o,
  output logic signed [15:0] output_value_o,
  output logic [3:0]         chosen_action_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i
);
  import mfa_pkg::*;

  localparam int NCOLS = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH;
  localparam int NROWS = (MAX_OUTPUTS > MAX_WIDTH) ? MAX_OUTPUTS : MAX_WIDTH;
  localparam int NMAX = (NCOLS > NROWS) ? NCOLS : NROWS;
  localparam int CNT_W = $clog2(NMAX + 1);
  localparam int SLOT_W = $clog2(MAX_HIDDEN_LAYERS + 1);

  logic              busy;
  logic              in_xfer;
  logic              start;
  logic              out_taken;
  dp_cmd_t           cmd;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  row_ctr;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  k;
  logic              src_bank;
  logic              dst_bank;
  act_e              kind;

  // Input transfers are taken only while idle; a flagged sample starts a pass.
  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;
  assign start      = in_xfer && (mode_i == MODE_SAMPLE) && last_element_i;

  mfa_ctrl #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_WIDTH(MAX_WIDTH),
    .MAX_OUTPUTS(MAX_OUTPUTS), .MAX_HIDDEN_LAYERS(MAX_HIDDEN_LAYERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start),
    .out_taken_i (out_taken),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .slot_o      (slot),
    .row_o       (row_ctr),
    .col_o       (col),
    .k_o         (k),
    .src_bank_o  (src_bank),
    .dst_bank_o  (dst_bank),
    .kind_o      (kind)
  );

  mfa_dpath #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_WIDTH(MAX_WIDTH),
    .MAX_OUTPUTS(MAX_OUTPUTS), .MAX_HIDDEN_LAYERS(MAX_HIDDEN_LAYERS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ld_en_i         (in_xfer),
    .mode_i          (mode_i),
    .layer_select_i  (layer_select_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .slot_i          (slot),
    .row_ctr_i       (row_ctr),
    .col_i           (col),
    .k_i             (k),
    .src_bank_i      (src_bank),
    .dst_bank_i      (dst_bank),
    .kind_i          (kind),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .output_index_o  (output_index_o),
    .output_value_o  (output_value_o),
    .chosen_action_o (chosen_action_o),
    .last_o          (last_o),
    .out_taken_o     (out_taken)
  );

  // A result is only offered while the block refuses new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input is open");

  // A flagged sample transfer closes the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == MODE_SAMPLE) && last_element_i) |=> in_stall_o)
    else $error("pass did not start after the last sample");

  // Transfer of the final result reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (!in_stall_o && !out_valid_o))
    else $error("block not idle after the final result");

endmodule

[rtl/mfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mfa_ram #(
  parameter int Width = 16,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mfa_ctrl.sv]
// Controller of the network inference block: configuration registers and the
// sequencer that walks layers, neurons and columns. Depends on mfa_pkg.
module mfa_ctrl #(
  parameter int MAX_INPUTS = 32,
  parameter int MAX_WIDTH = 32,
  parameter int MAX_OUTPUTS = 16,
  parameter int MAX_HIDDEN_LAYERS = 4,
  localparam int NCOLS = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH,
  localparam int NROWS = (MAX_OUTPUTS > MAX_WIDTH) ? MAX_OUTPUTS : MAX_WIDTH,
  localparam int NMAX = (NCOLS > NROWS) ? NCOLS : NROWS,
  localparam int CNT_W = $clog2(NMAX + 1),
  localparam int SLOT_W = $clog2(MAX_HIDDEN_LAYERS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [5:0]           cfg_data_i,
  input  logic                 start_i,
  input  logic                 out_taken_i,
  output logic                 busy_o,
  output mfa_pkg::dp_cmd_t     cmd_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [CNT_W-1:0]     row_o,
  output logic [CNT_W-1:0]     col_o,
  output logic [CNT_W-1:0]     k_o,
  output logic                 src_bank_o,
  output logic                 dst_bank_o,
  output mfa_pkg::act_e        kind_o
);
  import mfa_pkg::*;

  localparam int H_W = (MAX_HIDDEN_LAYERS > 1) ? $clog2(MAX_HIDDEN_LAYERS) : 1;
  localparam int HC_W = $clog2(MAX_HIDDEN_LAYERS + 1);

  logic [5:0] in_cnt_q;
  logic [4:0] out_cnt_q;
  logic [2:0] lay_cnt_q;
  logic [5:0] hsize_q [4];
  logic [2:0] act_mode_q;

  ctl_state_e state_q, state_d;
  logic [H_W-1:0]   h_q;
  logic             out_q;
  logic [CNT_W-1:0] nsrc_q;
  logic [CNT_W-1:0] nrows_q;
  logic [CNT_W-1:0] row_q;
  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] k_q;
  logic             drain_q;

  logic [CNT_W-1:0] n_in;
  logic [CNT_W-1:0] n_out;
  logic [HC_W-1:0]  n_hid;
  logic [H_W-1:0]   h_next;
  logic             last_hidden;
  logic             last_col;
  logic             last_row;
  logic             last_k;

  function automatic logic [CNT_W-1:0] hsize(logic [5:0] raw);
    return CNT_W'(clamp_int(int'(raw), 1, MAX_WIDTH));
  endfunction

  // Configuration registers keep the raw bits; clamping happens at use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q   <= 6'd1;
      out_cnt_q  <= 5'd1;
      lay_cnt_q  <= 3'd3;
      hsize_q[0] <= 6'd1;
      hsize_q[1] <= 6'd0;
      hsize_q[2] <= 6'd0;
      hsize_q[3] <= 6'd0;
      act_mode_q <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INPUT_COUNT:  in_cnt_q   <= cfg_data_i;
        CFG_OUTPUT_COUNT: out_cnt_q  <= cfg_data_i[4:0];
        CFG_LAYER_COUNT:  lay_cnt_q  <= cfg_data_i[2:0];
        CFG_HIDDEN1:      hsize_q[0] <= cfg_data_i;
        CFG_HIDDEN2:      hsize_q[1] <= cfg_data_i;
        CFG_HIDDEN3:      hsize_q[2] <= cfg_data_i;
        CFG_HIDDEN4:      hsize_q[3] <= cfg_data_i;
        CFG_ACT_MODE:     act_mode_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and loop-end conditions.
  assign n_in   = CNT_W'(clamp_int(int'(in_cnt_q), 1, MAX_INPUTS));
  assign n_out  = CNT_W'(clamp_int(int'(out_cnt_q), 1, MAX_OUTPUTS));
  assign n_hid  = HC_W'(clamp_int(int'(lay_cnt_q), 3, 2 + MAX_HIDDEN_LAYERS) - 2);
  assign h_next = H_W'(h_q + 1'b1);
  assign last_hidden = (HC_W'(h_q) + HC_W'(1)) == n_hid;
  assign last_col = (col_q + CNT_W'(1)) == nsrc_q;
  assign last_row = (row_q + CNT_W'(1)) == nrows_q;
  assign last_k   = (k_q + CNT_W'(1)) == n_out;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_BIAS;
      ST_BIAS:  state_d = ST_MAC;
      ST_MAC:   if (last_col) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q) state_d = ST_SAT;
      ST_SAT:   state_d = ST_ACT;
      ST_ACT:   state_d = (last_row && out_q) ? ST_ORD : ST_BIAS;
      ST_ORD:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_taken_i) state_d = last_k ? ST_IDLE : ST_ORD;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // State and loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q     <= '0;
      out_q   <= 1'b0;
      nsrc_q  <= '0;
      nrows_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            h_q     <= '0;
            out_q   <= 1'b0;
            nsrc_q  <= n_in;
            nrows_q <= hsize(hsize_q[0]);
            row_q   <= '0;
          end
        end
        ST_BIAS: col_q <= '0;
        ST_MAC: begin
          col_q   <= col_q + CNT_W'(1);
          drain_q <= 1'b0;
        end
        ST_DRAIN: drain_q <= 1'b1;
        ST_ACT: begin
          if (last_row) begin
            row_q <= '0;
            k_q   <= '0;
            if (!out_q) begin
              nsrc_q <= nrows_q;
              if (last_hidden) begin
                out_q   <= 1'b1;
                nrows_q <= n_out;
              end else begin
                h_q     <= h_next;
                nrows_q <= hsize(hsize_q[h_next]);
              end
            end
          end else begin
            row_q <= row_q + CNT_W'(1);
          end
        end
        ST_OUT: if (out_taken_i) k_q <= k_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Commands per state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.src_act   = out_q | (h_q != '0);
    cmd_o.out_layer = out_q;
    case (state_q)
      ST_BIAS: cmd_o.bias_rd = 1'b1;
      ST_MAC: begin
        cmd_o.mac_rd   = 1'b1;
        cmd_o.acc_load = (col_q == '0);
      end
      ST_SAT: cmd_o.sat_en = 1'b1;
      ST_ACT: begin
        cmd_o.act_wr    = 1'b1;
        cmd_o.arg_first = (row_q == '0);
      end
      ST_ORD: cmd_o.out_rd = 1'b1;
      ST_LOAD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.res_last = last_k;
      end
      default: ;
    endcase
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign slot_o     = out_q ? SLOT_W'(MAX_HIDDEN_LAYERS) : SLOT_W'(h_q);
  assign row_o      = row_q;
  assign col_o      = col_q;
  assign k_o        = k_q;
  assign src_bank_o = out_q ? h_q[0] : ~h_q[0];
  assign dst_bank_o = h_q[0];
  assign kind_o     = out_q ? act_e'(act_mode_q[2:1]) : (act_mode_q[0] ? ACT_TANH : ACT_LEAKY);

endmodule

[rtl/mfa_dpath.sv]
// Datapath of the network inference block: parameter and activation
// memories, multiply-accumulate, saturation, activation, argmax and the
// output register. Depends on mfa_pkg and mfa_ram.
module mfa_dpath #(
  parameter int MAX_INPUTS = 32,
  parameter int MAX_WIDTH = 32,
  parameter int MAX_OUTPUTS = 16,
  parameter int MAX_HIDDEN_LAYERS = 4,
  localparam int NCOLS = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH,
  localparam int NROWS = (MAX_OUTPUTS > MAX_WIDTH) ? MAX_OUTPUTS : MAX_WIDTH,
  localparam int NMAX = (NCOLS > NROWS) ? NCOLS : NROWS,
  localparam int CNT_W = $clog2(NMAX + 1),
  localparam int SLOT_W = $clog2(MAX_HIDDEN_LAYERS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ld_en_i,
  input  logic [1:0]           mode_i,
  input  logic [2:0]           layer_select_i,
  input  logic [4:0]           row_i,
  input  logic [4:0]           column_i,
  input  logic signed [15:0]   value_i,
  input  mfa_pkg::dp_cmd_t     cmd_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [CNT_W-1:0]     row_ctr_i,
  input  logic [CNT_W-1:0]     col_i,
  input  logic [CNT_W-1:0]     k_i,
  input  logic                 src_bank_i,
  input  logic                 dst_bank_i,
  input  mfa_pkg::act_e        kind_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [3:0]           output_index_o,
  output logic signed [15:0]   output_value_o,
  output logic [3:0]           chosen_action_o,
  output logic                 last_o,
  output logic                 out_taken_o
);
  import mfa_pkg::*;

  localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int COL_W = (NCOLS > 1) ? $clog2(NCOLS) : 1;
  localparam int IN_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int WD_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int OUT_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int NSLOTS = MAX_HIDDEN_LAYERS + 1;
  localparam int W_DEPTH = NSLOTS << (ROW_W + COL_W);
  localparam int B_DEPTH = NSLOTS << ROW_W;
  localparam int A_DEPTH = 2 << WD_W;
  localparam int ACC_W = 33 + $clog2(NCOLS);

  logic              slot_ok;
  logic [SLOT_W-1:0] ld_slot;
  logic              w_we;
  logic              b_we;
  logic              s_we;
  logic [15:0]       w_rd;
  logic [15:0]       b_rd;
  logic [15:0]       s_rd;
  logic [15:0]       a_rd;
  logic [15:0]       o_rd;
  logic              a_we;
  logic              o_we;

  logic                    v1_q;
  logic                    v2_q;
  logic signed [31:0]      p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [15:0]      sat_q;
  logic signed [15:0]      act_val;
  logic signed [15:0]      src_val;
  logic signed [15:0]      best_val_q;
  logic [3:0]              best_idx_q;

  logic                    out_valid_q;
  logic [3:0]              out_idx_q;
  logic signed [15:0]      out_val_q;
  logic [3:0]              out_best_q;
  logic                    out_last_q;

  // Load decode.
  assign slot_ok = (layer_select_i == LSEL_OUTPUT) ||
                   (int'(layer_select_i) < MAX_HIDDEN_LAYERS);
  assign ld_slot = (layer_select_i == LSEL_OUTPUT) ? SLOT_W'(MAX_HIDDEN_LAYERS)
                                                   : SLOT_W'(layer_select_i);
  assign w_we = ld_en_i && (mode_i == MODE_WEIGHT) && slot_ok &&
                (int'(row_i) < NROWS) && (int'(column_i) < NCOLS);
  assign b_we = ld_en_i && (mode_i == MODE_BIAS) && slot_ok && (int'(row_i) < NROWS);
  assign s_we = ld_en_i && (mode_i == MODE_SAMPLE) && (int'(column_i) < MAX_INPUTS);

  mfa_ram #(.Width(16), .Depth(W_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({ld_slot, ROW_W'(row_i), COL_W'(column_i)}),
    .wdata_i (value_i),
    .raddr_i ({slot_i, ROW_W'(row_ctr_i), COL_W'(col_i)}),
    .rdata_o (w_rd)
  );

  mfa_ram #(.Width(16), .Depth(B_DEPTH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i ({ld_slot, ROW_W'(row_i)}),
    .wdata_i (value_i),
    .raddr_i ({slot_i, ROW_W'(row_ctr_i)}),
    .rdata_o (b_rd)
  );

  mfa_ram #(.Width(16), .Depth(MAX_INPUTS)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (IN_W'(column_i)),
    .wdata_i (value_i),
    .raddr_i (IN_W'(col_i)),
    .rdata_o (s_rd)
  );

  // Two banks of hidden activations: one layer reads one bank, writes the other.
  assign a_we = cmd_i.act_wr && !cmd_i.out_layer;
  assign o_we = cmd_i.act_wr && cmd_i.out_layer;

  mfa_ram #(.Width(16), .Depth(A_DEPTH)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i ({dst_bank_i, WD_W'(row_ctr_i)}),
    .wdata_i (act_val),
    .raddr_i ({src_bank_i, WD_W'(col_i)}),
    .rdata_o (a_rd)
  );

  mfa_ram #(.Width(16), .Depth(MAX_OUTPUTS)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (OUT_W'(row_ctr_i)),
    .wdata_i (act_val),
    .raddr_i (OUT_W'(k_i)),
    .rdata_o (o_rd)
  );

  assign src_val = cmd_i.src_act ? $signed(a_rd) : $signed(s_rd);

  // Multiply stage and accumulator; the bias enters shifted up by 12.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_rd;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_q <= $signed(w_rd) * src_val;
    end
    if (cmd_i.acc_load) begin
      acc_q <= {{(ACC_W - 28){b_rd[15]}}, b_rd, 12'b0};
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(p_q);
    end
  end

  // Floor shift by 12 and saturation to Q4.12.
  assign acc_sh = acc_q >>> 12;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat_en) begin
      if (acc_sh > $signed(ACC_W'(32767))) begin
        sat_q <= 16'sh7fff;
      end else if (acc_sh < $signed(ACC_W'(-32768))) begin
        sat_q <= 16'sh8000;
      end else begin
        sat_q <= acc_sh[15:0];
      end
    end
  end

  assign act_val = mfa_activate(sat_q, kind_i);

  // First maximum over the output layer.
  always_ff @(posedge clk_i) begin
    if (o_we && (cmd_i.arg_first || (act_val > best_val_q))) begin
      best_val_q <= act_val;
      best_idx_q <= 4'(row_ctr_i);
    end
  end

  // Output register.
  assign out_taken_o = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_taken_o) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= 4'(k_i);
      out_val_q  <= o_rd;
      out_best_q <= best_idx_q;
      out_last_q <= cmd_i.res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign output_index_o  = out_idx_q;
  assign output_value_o  = out_val_q;
  assign chosen_action_o = out_best_q;
  assign last_o          = out_last_q;

endmodule
